@@ rtl/efc_pkg.sv @@
// Shared types, codes and CRC-8 helper for the encoder frame checker.
// No dependencies; imported by every module of the block.
package efc_pkg;

	localparam int DataW = 8;

	// register indexes on the config port
	localparam logic REG_TRIP_LEVEL   = 1'b0;
	localparam logic REG_FAULT_ENABLE = 1'b1;

	// error kinds
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_CRC    = 2'd1;
	localparam logic [1:0] ERR_MAGNET = 2'd2;

	localparam logic [7:0] THRESHOLD_RST = 8'd3;
	localparam logic [7:0] COUNT_MAX     = 8'hFF;

	// CRC-8 poly 0x07, init 0: message bit i contributes x^(i+8) mod P
	localparam logic [23:0][7:0] CRC_COL = {
		8'h0B, 8'h86, 8'h43, 8'hA2, 8'h51, 8'hAB, 8'hD6, 8'h6B,
		8'hB6, 8'h5B, 8'hAE, 8'h57, 8'hA8, 8'h54, 8'h2A, 8'h15,
		8'h89, 8'hC7, 8'hE0, 8'h70, 8'h38, 8'h1C, 8'h0E, 8'h07
	};

	typedef struct packed {
		logic [7:0] angle_high_byte;
		logic [7:0] angle_mid_byte;
		logic [7:0] angle_low_status_byte;
		logic [7:0] frame_crc;
	} efc_frame_t;

	typedef struct packed {
		logic [7:0] trip_level;
		logic       fault_enable;
	} efc_cfg_t;

	typedef struct packed {
		logic        frame_ok;
		logic [15:0] angle;
		logic [1:0]  error_kind;
		logic        over_speed;
		logic        no_magnet;
		logic        undervoltage;
		logic        fault_event;
	} efc_result_t;

	// parallel CRC over {b0, b1, b2}, b0 first
	function automatic logic [7:0] crc8_24(input logic [23:0] msg);
		logic [7:0] c;
		c = 8'h00;
		for (int i = 0; i < 24; i++) begin
			if (msg[i]) begin
				c = c ^ CRC_COL[i];
			end
		end
		return c;
	endfunction

endpackage

@@ rtl/encoder_frame_checker_core.sv @@
// channel  | dir | bits                                  | accepted when
// s_axis   | in  | tdata 32: high, mid, low_status, crc  | s_axis_tvalid & s_axis_tready
// m_axis   | out | tdata 24: see port comment            | m_axis_tvalid & m_axis_tready
// cfg      | in  | index 1, data 8                       | cfg_we
// An input word passes the input register, then the result register, to become the result word.
// One word per cycle sustained while m_axis accepts; the single frame evaluation sits
// between the two registers. A stall at m_axis fills both stages, then drops
// s_axis_tready. Async active-low reset empties the pipe and restores
// threshold 3, fault disabled, counters and latches clear.
// Depends on efc_pkg and efc_frame_eval.
module encoder_frame_checker_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] angle_high_byte, [15:8] angle_mid_byte,
	// [23:16] angle_low_status_byte, [31:24] frame_crc
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] frame_ok, [16:1] angle, [18:17] error_kind, [19] over_speed,
	// [20] no_magnet, [21] undervoltage, [22] fault_event, [23] zero
	output logic [23:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [efc_pkg::DataW-1:0] cfg_data
);
	import efc_pkg::*;

	efc_cfg_t    cfg_q;
	efc_frame_t  frame_s1;
	logic        vld_s1;
	efc_result_t res;
	efc_result_t res_s2;
	logic        vld_s2;
	logic        adv;

	assign adv           = vld_s1 && (!vld_s2 || m_axis_tready);
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trip_level   <= THRESHOLD_RST;
			cfg_q.fault_enable <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRIP_LEVEL:   cfg_q.trip_level   <= cfg_data;
				REG_FAULT_ENABLE: cfg_q.fault_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			frame_s1.angle_high_byte       <= s_axis_tdata[7:0];
			frame_s1.angle_mid_byte        <= s_axis_tdata[15:8];
			frame_s1.angle_low_status_byte <= s_axis_tdata[23:16];
			frame_s1.frame_crc             <= s_axis_tdata[31:24];
		end
	end

	efc_frame_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_s1),
		.cfg    (cfg_q),
		.commit (adv),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata  = {1'b0, res_s2.fault_event, res_s2.undervoltage,
		res_s2.no_magnet, res_s2.over_speed, res_s2.error_kind, res_s2.angle,
		res_s2.frame_ok};

endmodule

@@ rtl/efc_frame_eval.sv @@
// Frame evaluation: CRC check, status latch, error counter and fault latch.
// Depends on efc_pkg. State advances only when commit is high.
module efc_frame_eval (
	input  logic                 clk,
	input  logic                 arst_n,
	input  efc_pkg::efc_frame_t  frame,
	input  efc_pkg::efc_cfg_t    cfg,
	input  logic                 commit,
	output efc_pkg::efc_result_t result
);
	import efc_pkg::*;

	logic [7:0] error_count_q;
	logic       fault_latched_q;
	logic [2:0] warning_flags_q;

	logic [7:0] crc;
	logic       crc_ok;
	logic       magnet_bad;
	logic       bad;
	logic [7:0] count_inc;
	logic       fire;
	logic [2:0] flags_next;

	always_comb begin
		crc        = crc8_24({frame.angle_high_byte, frame.angle_mid_byte,
			frame.angle_low_status_byte});
		crc_ok     = (crc == frame.frame_crc);
		magnet_bad = crc_ok && frame.angle_low_status_byte[1];
		bad        = !crc_ok || magnet_bad;
		count_inc  = (error_count_q == COUNT_MAX) ? COUNT_MAX : error_count_q + 8'd1;
		fire       = bad && (count_inc >= cfg.trip_level) && cfg.fault_enable
			&& !fault_latched_q;
		flags_next = crc_ok ? frame.angle_low_status_byte[2:0] : warning_flags_q;

		result.frame_ok     = !bad;
		result.angle        = bad ? 16'h0000
			: {frame.angle_high_byte, frame.angle_mid_byte};
		result.error_kind   = !crc_ok ? ERR_CRC : (magnet_bad ? ERR_MAGNET : ERR_NONE);
		result.over_speed   = flags_next[0];
		result.no_magnet    = flags_next[1];
		result.undervoltage = flags_next[2];
		result.fault_event  = fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_count_q   <= '0;
			fault_latched_q <= 1'b0;
			warning_flags_q <= '0;
		end else if (commit) begin
			warning_flags_q <= flags_next;
			if (bad) begin
				error_count_q <= count_inc;
				if (fire) begin
					fault_latched_q <= 1'b1;
				end
			end else begin
				error_count_q   <= '0;
				fault_latched_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/efc_checker.sv @@
// Port-level checks on result words of encoder_frame_checker_core.
// Depends on efc_pkg; bound to the top level below.
module efc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic [23:0] m_axis_tdata
);
	import efc_pkg::*;

	logic       ok;
	logic [1:0] kind;

	assign ok   = m_axis_tdata[0];
	assign kind = m_axis_tdata[18:17];

	// a rejected frame carries no angle
	a_angle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !ok |-> m_axis_tdata[16:1] == 16'h0000)
		else $error("angle nonzero on rejected word");

	// good frame and error kind agree
	a_kind_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (ok == (kind == ERR_NONE)) && (kind != 2'd3))
		else $error("frame_ok and error_kind disagree");

	// weak-magnet rejection means the latched flag is set
	a_magnet_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && kind == ERR_MAGNET |-> m_axis_tdata[20])
		else $error("magnet error without no_magnet flag");

	// fault event only on a rejected word
	a_event_bad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[22] |-> !ok)
		else $error("fault event on good word");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !m_axis_tdata[23])
		else $error("pad bit set");

endmodule

bind encoder_frame_checker_core efc_checker u_efc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tdata  (m_axis_tdata)
);
